// ----- hdl/rrts_pkg.sv -----
// ----------------------------------------------------------------------------
// Round-robin task switcher package
// Shared types and fixed constants of the task switcher and its checker.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int MAX_SLOTS      = 8;
    localparam int SLOT_W         = 3;
    localparam int SLOT_ID_W      = 4;
    localparam int WORD_W         = 64;
    localparam int SLICE_W        = 32;
    localparam int CFG_IDX_W      = 1;
    localparam int PTR_ALIGN_BITS = 3;

    localparam logic [SLOT_ID_W-1:0] NO_SLOT     = SLOT_ID_W'(MAX_SLOTS);
    localparam logic [WORD_W-1:0]    STACK_BYTES = 64'd32768;
    localparam logic [WORD_W-1:0]    FRAME_BYTES = 64'd176;
    localparam logic [WORD_W-1:0]    TOP_MASK    = ~64'hF;

    typedef enum logic [1:0] {
        ACT_ADD,
        ACT_START,
        ACT_TICK,
        ACT_STATS
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SLICE_TICKS,
        CFG_STACK_BASE
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_BOUND,
        ST_CHECK,
        ST_ADD,
        ST_SAVE,
        ST_COMMIT,
        ST_STATS,
        ST_FINISH
    } state_t;

endpackage

// ----- hdl/round_robin_task_switcher_unit.sv -----
// ----------------------------------------------------------------------------
// Round-robin task switcher
// Eight-slot task table with time-slice scheduling, stack pointer checks and
// per-slot run statistics kept in two single-port synchronous memories.
// ----------------------------------------------------------------------------
// One request at a time: a request is taken in the idle cycle, then runs a
// short sequence before its result is loaded into the output register.
// An add runs decode, bound, add and finish; a statistics read decode, bound,
// stats and finish; a start decode, bound, check, commit and finish. An add to
// a full table, a start with no tasks, a read of an unused slot and a timer
// tick with nothing to check or a zero pointer go from decode to finish. Other
// ticks run bound and check, and stop there when the pointer is bad; the rest
// go on through save, and those that switch tasks on through bound, check and
// commit (the bounds checks of the current and the next slot each pass a bound
// and a compare state around the memory read). A stalled output holds the
// result in finish. A new request is accepted while the previous result still
// waits at the output. The slot memories need no clearing after reset: an
// entry is read only after an add has written it.
module round_robin_task_switcher_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [rrts_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rrts_pkg::WORD_W-1:0]           cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            action,
    input  logic [rrts_pkg::WORD_W-1:0]           stack_pointer,
    input  logic [rrts_pkg::WORD_W-1:0]           current_tick,
    input  logic [rrts_pkg::SLOT_W-1:0]           slot_index,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [rrts_pkg::WORD_W-1:0]           resume_pointer,
    output logic                                  status,
    output logic [rrts_pkg::SLOT_ID_W-1:0]        chosen_slot,
    output logic                                  switched,
    output logic [rrts_pkg::WORD_W-1:0]           slot_runs,
    output logic [rrts_pkg::WORD_W-1:0]           slot_last_tick,
    output logic [rrts_pkg::SLOT_ID_W-1:0]        running_slot,
    output logic [rrts_pkg::SLOT_ID_W-1:0]        tasks_present
);

    localparam int W   = rrts_pkg::WORD_W;
    localparam int SW  = rrts_pkg::SLOT_W;
    localparam int SIW = rrts_pkg::SLOT_ID_W;
    localparam int NS  = rrts_pkg::MAX_SLOTS;

    rrts_pkg::state_t  state_reg, state_next;
    rrts_pkg::action_t act_reg;
    logic [W-1:0]      sp_reg;
    logic [W-1:0]      now_reg;
    logic [SW-1:0]     qidx_reg;

    logic [NS-1:0]     used_reg, used_next;
    logic [SIW-1:0]    count_reg, count_next;
    logic [SIW-1:0]    cur_reg, cur_next;
    logic [W-1:0]      last_switch_reg, last_switch_next;
    logic              running_reg, running_next;
    logic [rrts_pkg::SLICE_W-1:0] slice_reg;
    logic [W-1:0]      base_reg;

    logic [SW-1:0]     tgt_reg, tgt_next;
    logic              use_sp_reg, use_sp_next;
    logic              ok_reg, ok_next;
    logic [W-1:0]      lo_reg, lo_next;
    logic [W-1:0]      hi_reg, hi_next;
    logic [W-1:0]      lim_reg, lim_next;
    logic              wrap_reg, wrap_next;

    logic [W-1:0]      res_ptr_reg, res_ptr_next;
    logic              res_status_reg, res_status_next;
    logic [SIW-1:0]    res_chosen_reg, res_chosen_next;
    logic              res_sw_reg, res_sw_next;
    logic [W-1:0]      res_runs_reg, res_runs_next;
    logic [W-1:0]      res_last_reg, res_last_next;

    logic              out_valid_reg, out_valid_next;
    logic [W-1:0]      out_ptr_reg;
    logic              out_status_reg;
    logic [SIW-1:0]    out_chosen_reg;
    logic              out_sw_reg;
    logic [W-1:0]      out_runs_reg;
    logic [W-1:0]      out_last_reg;
    logic [SIW-1:0]    out_running_reg;
    logic [SIW-1:0]    out_tasks_reg;
    logic              load_out;

    logic [W-1:0]      ptr_mem [NS];
    logic [2*W-1:0]    cnt_mem [NS];
    logic [W-1:0]      ptr_q;
    logic [2*W-1:0]    cnt_q;
    logic              ptr_we;
    logic [W-1:0]      ptr_wdata;
    logic              cnt_we;
    logic [2*W-1:0]    cnt_wdata;

    logic [SIW-1:0]    low_used;
    logic [SIW-1:0]    low_free;
    logic [SIW-1:0]    after_cur;
    logic [SW-1:0]     cur_idx;
    logic              cur_valid;
    logic [W-1:0]      lo_off, hi_off, lim_off;
    logic [W:0]        lo_sum, hi_sum;
    logic [W-1:0]      chk_ptr;
    logic              chk_ok;
    logic              expired;
    logic [W-1:0]      init_top;

    assign in_ready  = (state_reg == rrts_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    assign cur_idx   = cur_reg[SW-1:0];
    assign cur_valid = (cur_reg < rrts_pkg::NO_SLOT) && used_reg[cur_idx];

    always_comb
    begin
        low_used = rrts_pkg::NO_SLOT;
        low_free = rrts_pkg::NO_SLOT;
        for (int i = NS - 1; i >= 0; i--)
        begin
            if (used_reg[i])
            begin
                low_used = SIW'(i);
            end
            else
            begin
                low_free = SIW'(i);
            end
        end
    end

    always_comb
    begin
        logic [SW-1:0] k;
        after_cur = rrts_pkg::NO_SLOT;
        for (int s = NS; s >= 1; s--)
        begin
            k = SW'((int'(cur_idx) + s) % NS);
            if (used_reg[k])
            begin
                after_cur = SIW'(k);
            end
        end
    end

    // slot stack bounds: low end, top, and highest pointer that fits a frame
    assign lo_off    = W'(tgt_reg) * rrts_pkg::STACK_BYTES;
    assign hi_off    = (W'(tgt_reg) + W'(1)) * rrts_pkg::STACK_BYTES;
    assign lim_off   = hi_off - rrts_pkg::FRAME_BYTES;
    assign lo_sum    = {1'b0, base_reg} + {1'b0, lo_off};
    assign hi_sum    = {1'b0, base_reg} + {1'b0, hi_off};
    assign lo_next   = lo_sum[W-1:0];
    assign hi_next   = hi_sum[W-1:0];
    assign wrap_next = hi_sum[W] & ~lo_sum[W];
    assign lim_next  = base_reg + lim_off;

    assign chk_ptr  = use_sp_reg ? sp_reg : ptr_q;
    assign chk_ok   = !wrap_reg && (chk_ptr[rrts_pkg::PTR_ALIGN_BITS-1:0] == '0)
                      && (chk_ptr >= lo_reg) && (chk_ptr <= lim_reg);
    assign expired  = (now_reg - last_switch_reg) >= W'(slice_reg);
    assign init_top = hi_reg & rrts_pkg::TOP_MASK;

    always_comb
    begin
        state_next       = state_reg;
        used_next        = used_reg;
        count_next       = count_reg;
        cur_next         = cur_reg;
        last_switch_next = last_switch_reg;
        running_next     = running_reg;
        tgt_next         = tgt_reg;
        use_sp_next      = use_sp_reg;
        ok_next          = ok_reg;
        res_ptr_next     = res_ptr_reg;
        res_status_next  = res_status_reg;
        res_chosen_next  = res_chosen_reg;
        res_sw_next      = res_sw_reg;
        res_runs_next    = res_runs_reg;
        res_last_next    = res_last_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        load_out         = 1'b0;
        ptr_we           = 1'b0;
        ptr_wdata        = sp_reg;
        cnt_we           = 1'b0;
        cnt_wdata        = '0;

        case (state_reg)
            rrts_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rrts_pkg::ST_DECODE;
                end
            end

            rrts_pkg::ST_DECODE:
            begin
                res_ptr_next    = sp_reg;
                res_status_next = 1'b0;
                res_chosen_next = rrts_pkg::NO_SLOT;
                res_sw_next     = 1'b0;
                res_runs_next   = '0;
                res_last_next   = '0;
                use_sp_next     = 1'b0;
                state_next      = rrts_pkg::ST_FINISH;
                case (act_reg)
                    rrts_pkg::ACT_ADD:
                    begin
                        res_status_next = 1'b1;
                        if (count_reg < rrts_pkg::NO_SLOT && low_free < rrts_pkg::NO_SLOT)
                        begin
                            tgt_next   = low_free[SW-1:0];
                            state_next = rrts_pkg::ST_BOUND;
                        end
                    end
                    rrts_pkg::ACT_START:
                    begin
                        if (count_reg == '0 || low_used == rrts_pkg::NO_SLOT)
                        begin
                            res_status_next = 1'b1;
                        end
                        else
                        begin
                            tgt_next   = low_used[SW-1:0];
                            state_next = rrts_pkg::ST_BOUND;
                        end
                    end
                    rrts_pkg::ACT_TICK:
                    begin
                        if (!running_reg || count_reg == '0)
                        begin
                            state_next = rrts_pkg::ST_FINISH;
                        end
                        else if (sp_reg == '0)
                        begin
                            res_status_next = 1'b1;
                        end
                        else if (!cur_valid)
                        begin
                            cur_next         = low_used;
                            last_switch_next = now_reg;
                        end
                        else
                        begin
                            tgt_next    = cur_idx;
                            use_sp_next = 1'b1;
                            state_next  = rrts_pkg::ST_BOUND;
                        end
                    end
                    rrts_pkg::ACT_STATS:
                    begin
                        if (used_reg[qidx_reg])
                        begin
                            tgt_next   = qidx_reg;
                            state_next = rrts_pkg::ST_BOUND;
                        end
                        else
                        begin
                            res_status_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = rrts_pkg::ST_FINISH;
                    end
                endcase
            end

            rrts_pkg::ST_BOUND:
            begin
                case (act_reg)
                    rrts_pkg::ACT_ADD:   state_next = rrts_pkg::ST_ADD;
                    rrts_pkg::ACT_STATS: state_next = rrts_pkg::ST_STATS;
                    default:             state_next = rrts_pkg::ST_CHECK;
                endcase
            end

            rrts_pkg::ST_CHECK:
            begin
                ok_next = chk_ok;
                if (!use_sp_reg)
                begin
                    state_next = rrts_pkg::ST_COMMIT;
                end
                else if (chk_ok)
                begin
                    state_next = rrts_pkg::ST_SAVE;
                end
                else
                begin
                    res_status_next = 1'b1;
                    state_next      = rrts_pkg::ST_FINISH;
                end
            end

            rrts_pkg::ST_ADD:
            begin
                if (init_top != rrts_pkg::FRAME_BYTES)
                begin
                    ptr_we          = 1'b1;
                    ptr_wdata       = init_top - rrts_pkg::FRAME_BYTES;
                    cnt_we          = 1'b1;
                    used_next       = used_reg | (NS'(1) << tgt_reg);
                    count_next      = count_reg + SIW'(1);
                    res_status_next = 1'b0;
                    res_chosen_next = SIW'(tgt_reg);
                end
                state_next = rrts_pkg::ST_FINISH;
            end

            rrts_pkg::ST_SAVE:
            begin
                ptr_we      = 1'b1;
                use_sp_next = 1'b0;
                state_next  = rrts_pkg::ST_FINISH;
                if (expired)
                begin
                    if (after_cur == rrts_pkg::NO_SLOT || after_cur == cur_reg)
                    begin
                        last_switch_next = now_reg;
                    end
                    else
                    begin
                        tgt_next   = after_cur[SW-1:0];
                        state_next = rrts_pkg::ST_BOUND;
                    end
                end
            end

            rrts_pkg::ST_COMMIT:
            begin
                cur_next         = SIW'(tgt_reg);
                running_next     = 1'b1;
                last_switch_next = now_reg;
                cnt_we           = 1'b1;
                cnt_wdata        = {cnt_q[2*W-1:W] + W'(1), now_reg};
                res_chosen_next  = SIW'(tgt_reg);
                res_sw_next      = (act_reg == rrts_pkg::ACT_TICK);
                if (ok_reg)
                begin
                    res_ptr_next = ptr_q;
                end
                else
                begin
                    res_status_next = 1'b1;
                end
                state_next = rrts_pkg::ST_FINISH;
            end

            rrts_pkg::ST_STATS:
            begin
                res_runs_next = cnt_q[2*W-1:W];
                res_last_next = cnt_q[W-1:0];
                state_next    = rrts_pkg::ST_FINISH;
            end

            rrts_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = rrts_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rrts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rrts_pkg::ST_IDLE;
            used_reg        <= '0;
            count_reg       <= '0;
            cur_reg         <= rrts_pkg::NO_SLOT;
            last_switch_reg <= '0;
            running_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            slice_reg       <= rrts_pkg::SLICE_W'(1);
            base_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            used_reg        <= used_next;
            count_reg       <= count_next;
            cur_reg         <= cur_next;
            last_switch_reg <= last_switch_next;
            running_reg     <= running_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (rrts_pkg::cfg_reg_t'(cfg_index))
                    rrts_pkg::CFG_SLICE_TICKS:
                    begin
                        if (cfg_data[rrts_pkg::SLICE_W-1:0] == '0)
                        begin
                            slice_reg <= rrts_pkg::SLICE_W'(1);
                        end
                        else
                        begin
                            slice_reg <= cfg_data[rrts_pkg::SLICE_W-1:0];
                        end
                    end
                    rrts_pkg::CFG_STACK_BASE:
                    begin
                        base_reg <= cfg_data;
                    end
                    default:
                    begin
                        base_reg <= base_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            act_reg  <= rrts_pkg::action_t'(action);
            sp_reg   <= stack_pointer;
            now_reg  <= current_tick;
            qidx_reg <= slot_index;
        end
        tgt_reg        <= tgt_next;
        use_sp_reg     <= use_sp_next;
        ok_reg         <= ok_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        lim_reg        <= lim_next;
        wrap_reg       <= wrap_next;
        res_ptr_reg    <= res_ptr_next;
        res_status_reg <= res_status_next;
        res_chosen_reg <= res_chosen_next;
        res_sw_reg     <= res_sw_next;
        res_runs_reg   <= res_runs_next;
        res_last_reg   <= res_last_next;
        if (load_out)
        begin
            out_ptr_reg     <= res_ptr_reg;
            out_status_reg  <= res_status_reg;
            out_chosen_reg  <= res_chosen_reg;
            out_sw_reg      <= res_sw_reg;
            out_runs_reg    <= res_runs_reg;
            out_last_reg    <= res_last_reg;
            out_running_reg <= cur_valid ? cur_reg : rrts_pkg::NO_SLOT;
            out_tasks_reg   <= count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ptr_we)
        begin
            ptr_mem[tgt_reg] <= ptr_wdata;
        end
        ptr_q <= ptr_mem[tgt_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[tgt_reg] <= cnt_wdata;
        end
        cnt_q <= cnt_mem[tgt_reg];
    end

    assign out_valid      = out_valid_reg;
    assign resume_pointer = out_ptr_reg;
    assign status         = out_status_reg;
    assign chosen_slot    = out_chosen_reg;
    assign switched       = out_sw_reg;
    assign slot_runs      = out_runs_reg;
    assign slot_last_tick = out_last_reg;
    assign running_slot   = out_running_reg;
    assign tasks_present  = out_tasks_reg;

endmodule

// ----- hdl/rrts_checker.sv -----
// ----------------------------------------------------------------------------
// Round-robin task switcher checker
// Port-level properties of the task switcher, bound to its top level.
// ----------------------------------------------------------------------------
module rrts_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic [rrts_pkg::WORD_W-1:0]           resume_pointer,
    input logic [rrts_pkg::SLOT_ID_W-1:0]        chosen_slot,
    input logic                                  switched,
    input logic [rrts_pkg::SLOT_ID_W-1:0]        running_slot,
    input logic [rrts_pkg::SLOT_ID_W-1:0]        tasks_present
);

    logic [rrts_pkg::SLOT_ID_W-1:0] prev_tasks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_tasks_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            prev_tasks_reg <= tasks_present;
        end
    end

    // slots are never freed, so the task count only grows
    a_tasks_grow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |-> tasks_present >= prev_tasks_reg)
        else $error("task count dropped between requests");

    a_switch_target: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && switched |->
            chosen_slot != rrts_pkg::NO_SLOT && running_slot == chosen_slot)
        else $error("switch does not land on the chosen slot");

    // used slots fill from the bottom, so every named slot lies below the count
    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (chosen_slot == rrts_pkg::NO_SLOT || chosen_slot < tasks_present) &&
            (running_slot == rrts_pkg::NO_SLOT || running_slot < tasks_present))
        else $error("slot outside the used range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(resume_pointer))
        else $error("stalled result changed");

endmodule

bind round_robin_task_switcher_unit rrts_checker u_rrts_checker (.*);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// Round-robin task switcher testbench
// Drives add, start, timer tick and statistics requests through the
// request channel and predicts every result from a model of the task table
// kept here. Results are compared field by field. The register settings walk
// through slice lengths and stack region bases, including wrapping regions.
// Both channels idle at random, and the result side holds off twice for a
// long stretch.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_W         = rrts_pkg::WORD_W;
    localparam int SLOT_W         = rrts_pkg::SLOT_W;
    localparam int SLOT_ID_W      = rrts_pkg::SLOT_ID_W;
    localparam int CFG_IDX_W      = rrts_pkg::CFG_IDX_W;
    localparam int SLICE_W        = rrts_pkg::SLICE_W;
    localparam int MAX_SLOTS      = rrts_pkg::MAX_SLOTS;
    localparam int PTR_ALIGN_BITS = rrts_pkg::PTR_ALIGN_BITS;

    localparam logic [SLOT_ID_W-1:0] NO_SLOT     = rrts_pkg::NO_SLOT;
    localparam logic [WORD_W-1:0]    STACK_BYTES = rrts_pkg::STACK_BYTES;
    localparam logic [WORD_W-1:0]    FRAME_BYTES = rrts_pkg::FRAME_BYTES;
    localparam logic [WORD_W-1:0]    TOP_MASK    = rrts_pkg::TOP_MASK;

    localparam int SETTINGS_N     = 6;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct {
        rrts_pkg::action_t act;
        logic [WORD_W-1:0] sp;
        logic [WORD_W-1:0] now;
        logic [SLOT_W-1:0] qidx;
    } sched_req_t;

    typedef struct {
        logic [WORD_W-1:0]    resume;
        logic                 status;
        logic [SLOT_ID_W-1:0] chosen;
        logic                 sw;
        logic [WORD_W-1:0]    runs;
        logic [WORD_W-1:0]    last;
        logic [SLOT_ID_W-1:0] run_slot;
        logic [SLOT_ID_W-1:0] present;
    } sched_rsp_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_valid     = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index     = '0;
    logic [WORD_W-1:0]    cfg_data      = '0;
    logic                 in_valid      = 1'b0;
    logic                 in_ready;
    logic [1:0]           action        = '0;
    logic [WORD_W-1:0]    stack_pointer = '0;
    logic [WORD_W-1:0]    current_tick  = '0;
    logic [SLOT_W-1:0]    slot_index    = '0;
    logic                 out_valid;
    logic                 out_ready     = 1'b0;
    logic [WORD_W-1:0]    resume_pointer;
    logic                 status;
    logic [SLOT_ID_W-1:0] chosen_slot;
    logic                 switched;
    logic [WORD_W-1:0]    slot_runs;
    logic [WORD_W-1:0]    slot_last_tick;
    logic [SLOT_ID_W-1:0] running_slot;
    logic [SLOT_ID_W-1:0] tasks_present;

    // task table model
    logic [SLICE_W-1:0] slice_len   = 32'd1;
    logic [WORD_W-1:0]  region_base = '0;
    bit                 tsk_used [MAX_SLOTS];
    logic [WORD_W-1:0]  tsk_sp   [MAX_SLOTS];
    logic [WORD_W-1:0]  tsk_runs [MAX_SLOTS];
    logic [WORD_W-1:0]  tsk_tick [MAX_SLOTS];
    int                 tsk_count   = 0;
    int                 cur_slot    = MAX_SLOTS;
    logic [WORD_W-1:0]  slice_start = '0;
    bit                 sched_on    = 1'b0;
    logic [WORD_W-1:0]  tick_clock  = '0;

    sched_req_t pend_q [$];
    sched_rsp_t rsp_q [$];
    sched_req_t live_req = '{act: rrts_pkg::ACT_ADD, default: '0};
    sched_rsp_t prediction;
    sched_rsp_t seen_rsp;
    sched_rsp_t want_rsp;
    bit         req_live    = 1'b0;
    bit         steady_pace = 1'b0;
    int         send_wait   = 0;
    int         ack_wait    = 0;
    int         issued      = 0;
    int         accepted    = 0;
    int         checked     = 0;
    int         mismatches  = 0;
    int         switches    = 0;
    int         rejects     = 0;
    int         cfg_writes  = 0;
    int         idle_cycles = 0;
    int         act_count [4];

    logic [WORD_W-1:0] setting_slice [SETTINGS_N] = '{
        64'h0000_0000_0000_0001, 64'hA5A5_0000_0000_0000, 64'h0000_0000_0000_0003,
        64'h0000_0000_FFFF_FFFF, 64'h5A5A_5A5A_0000_0007, 64'h0000_0000_0000_0002
    };
    logic [WORD_W-1:0] setting_base [SETTINGS_N] = '{
        64'h0000_0000_0000_0000, 64'h0000_1234_5678_9AB3, 64'hFFFF_FFFF_FFFF_0000,
        64'h7FFF_FFFF_FFFC_0008, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000
    };
    int setting_items [SETTINGS_N] = '{300, 250, 150, 250, 100, 420};
    bit setting_steady [SETTINGS_N] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0};

    round_robin_task_switcher_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .stack_pointer  (stack_pointer),
        .current_tick   (current_tick),
        .slot_index     (slot_index),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .resume_pointer (resume_pointer),
        .status         (status),
        .chosen_slot    (chosen_slot),
        .switched       (switched),
        .slot_runs      (slot_runs),
        .slot_last_tick (slot_last_tick),
        .running_slot   (running_slot),
        .tasks_present  (tasks_present)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [WORD_W-1:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    function automatic int draw_wait();
        if (steady_pace || $urandom_range(0, 4) == 0)
        begin
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic logic [WORD_W-1:0] stack_floor(int s);
        return region_base + 64'(s) * STACK_BYTES;
    endfunction

    function automatic bit sp_in_stack(int s, logic [WORD_W-1:0] p);
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        if (s >= MAX_SLOTS)
        begin
            return 1'b0;
        end
        lo = stack_floor(s);
        hi = lo + STACK_BYTES;
        return (hi >= lo) && (p[PTR_ALIGN_BITS-1:0] == '0) && (p >= lo)
            && (p <= hi - FRAME_BYTES);
    endfunction

    function automatic bit slot_live(int s);
        return (s < MAX_SLOTS) && tsk_used[s];
    endfunction

    function automatic int first_used();
        int s;
        int found;
        found = MAX_SLOTS;
        for (s = MAX_SLOTS - 1; s >= 0; s--)
        begin
            if (tsk_used[s])
            begin
                found = s;
            end
        end
        return found;
    endfunction

    function automatic void launch(int s, logic [WORD_W-1:0] now, inout sched_rsp_t r);
        cur_slot    = s;
        slice_start = now;
        tsk_runs[s] = tsk_runs[s] + 64'd1;
        tsk_tick[s] = now;
        r.chosen    = SLOT_ID_W'(s);
        if (sp_in_stack(s, tsk_sp[s]))
        begin
            r.resume = tsk_sp[s];
        end
        else
        begin
            r.status = 1'b1;
        end
    endfunction

    function automatic sched_rsp_t predict_step(sched_req_t rq);
        sched_rsp_t        r;
        int                s;
        int                k;
        int                nx;
        bit                placed;
        logic [WORD_W-1:0] init_sp;
        r = '{rq.sp, 1'b0, NO_SLOT, 1'b0, '0, '0, NO_SLOT, '0};
        case (rq.act)
            rrts_pkg::ACT_ADD:
            begin
                r.status = 1'b1;
                placed   = 1'b0;
                if (tsk_count < MAX_SLOTS)
                begin
                    for (s = 0; s < MAX_SLOTS; s++)
                    begin
                        if (!placed && !tsk_used[s])
                        begin
                            placed  = 1'b1;
                            init_sp = ((stack_floor(s) + STACK_BYTES) & TOP_MASK) - FRAME_BYTES;
                            if (init_sp != '0)
                            begin
                                tsk_used[s] = 1'b1;
                                tsk_sp[s]   = init_sp;
                                tsk_runs[s] = '0;
                                tsk_tick[s] = '0;
                                tsk_count++;
                                r.status = 1'b0;
                                r.chosen = SLOT_ID_W'(s);
                            end
                        end
                    end
                end
            end
            rrts_pkg::ACT_START:
            begin
                s = first_used();
                if (tsk_count == 0 || s >= MAX_SLOTS)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    sched_on = 1'b1;
                    launch(s, rq.now, r);
                end
            end
            rrts_pkg::ACT_TICK:
            begin
                if (sched_on && tsk_count != 0)
                begin
                    if (rq.sp == '0)
                    begin
                        r.status = 1'b1;
                    end
                    else if (!slot_live(cur_slot))
                    begin
                        cur_slot    = first_used();
                        slice_start = rq.now;
                    end
                    else if (!sp_in_stack(cur_slot, rq.sp))
                    begin
                        r.status = 1'b1;
                    end
                    else
                    begin
                        tsk_sp[cur_slot] = rq.sp;
                        if (rq.now - slice_start >= WORD_W'(slice_len))
                        begin
                            nx = MAX_SLOTS;
                            for (k = MAX_SLOTS; k >= 1; k--)
                            begin
                                if (tsk_used[(cur_slot + k) % MAX_SLOTS])
                                begin
                                    nx = (cur_slot + k) % MAX_SLOTS;
                                end
                            end
                            if (nx >= MAX_SLOTS || nx == cur_slot)
                            begin
                                slice_start = rq.now;
                            end
                            else
                            begin
                                launch(nx, rq.now, r);
                                r.sw = 1'b1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                if (tsk_used[rq.qidx])
                begin
                    r.runs = tsk_runs[rq.qidx];
                    r.last = tsk_tick[rq.qidx];
                end
                else
                begin
                    r.status = 1'b1;
                end
            end
        endcase
        r.run_slot = slot_live(cur_slot) ? SLOT_ID_W'(cur_slot) : NO_SLOT;
        r.present  = SLOT_ID_W'(tsk_count);
        return r;
    endfunction

    // mostly well-formed timer ticks on the running task, with noise mixed in
    function automatic sched_req_t random_req();
        sched_req_t        rq;
        int                pick;
        logic [WORD_W-1:0] lo;
        rq.sp   = rnd64();
        rq.qidx = SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
        pick    = $urandom_range(0, 99);
        if (pick < 4)
        begin
            rq.act = rrts_pkg::ACT_ADD;
        end
        else if (pick < 9)
        begin
            rq.act = rrts_pkg::ACT_START;
        end
        else if (pick < 80)
        begin
            rq.act = rrts_pkg::ACT_TICK;
        end
        else
        begin
            rq.act = rrts_pkg::ACT_STATS;
        end
        case ($urandom_range(0, 9))
            0:       rq.now = rnd64();
            1:       rq.now = slice_start + WORD_W'(slice_len);
            2:       rq.now = slice_start + WORD_W'(slice_len) - 64'd1;
            3:       rq.now = slice_start - 64'd1;
            default: rq.now = tick_clock + 64'($urandom_range(0, 6));
        endcase
        tick_clock = rq.now;
        if (rq.act == rrts_pkg::ACT_TICK && cur_slot < MAX_SLOTS)
        begin
            lo = stack_floor(cur_slot);
            case ($urandom_range(0, 19))
                0:       rq.sp = '0;
                1:       rq.sp = lo + 64'(8 * $urandom_range(0, 4000) + $urandom_range(1, 7));
                2:       rq.sp = lo - 64'd8;
                3:       rq.sp = lo + STACK_BYTES - FRAME_BYTES + 64'd8;
                4:       rq.sp = rnd64();
                5:       rq.sp = lo;
                6:       rq.sp = lo + STACK_BYTES - FRAME_BYTES;
                default: rq.sp = ((lo + 64'd7) & ~64'd7) + 64'(8 * $urandom_range(0, 4000));
            endcase
        end
        return rq;
    endfunction

    function automatic string fmt_rsp(sched_rsp_t r);
        return $sformatf("resume=%h status=%0d chosen=%0d switched=%0d runs=%h last=%h run=%0d n=%0d",
                         r.resume, r.status, r.chosen, r.sw, r.runs, r.last, r.run_slot,
                         r.present);
    endfunction

    task automatic wait_driver();
        wait (accepted == issued);
    endtask

    task automatic push_req(sched_req_t rq);
        wait_driver();
        pend_q.push_back(rq);
        issued++;
    endtask

    task automatic settle();
        wait (checked >= issued);
    endtask

    task automatic write_reg(rrts_pkg::cfg_reg_t idx, logic [WORD_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == rrts_pkg::CFG_SLICE_TICKS)
        begin
            slice_len = (data[SLICE_W-1:0] == '0) ? 32'd1 : data[SLICE_W-1:0];
        end
        else
        begin
            region_base = data;
        end
        cfg_writes++;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            req_live  = 1'b0;
            send_wait = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                prediction = predict_step(live_req);
                rsp_q.push_back(prediction);
                act_count[int'(live_req.act)]++;
                switches += prediction.sw;
                rejects  += prediction.status;
                accepted++;
                req_live  = 1'b0;
                send_wait = draw_wait();
            end
            if (!req_live)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                end
                else if (pend_q.size() > 0)
                begin
                    live_req = pend_q.pop_front();
                    req_live = 1'b1;
                end
            end
            in_valid      <= req_live;
            action        <= live_req.act;
            stack_pointer <= live_req.sp;
            current_tick  <= live_req.now;
            slot_index    <= live_req.qidx;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ack_wait   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen_rsp = '{resume_pointer, status, chosen_slot, switched, slot_runs,
                             slot_last_tick, running_slot, tasks_present};
                checked++;
                if (rsp_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result %0d with no request pending: %s", checked,
                                 fmt_rsp(seen_rsp));
                    end
                end
                else
                begin
                    want_rsp = rsp_q.pop_front();
                    if (seen_rsp.resume !== want_rsp.resume || seen_rsp.status !== want_rsp.status
                        || seen_rsp.chosen !== want_rsp.chosen || seen_rsp.sw !== want_rsp.sw
                        || seen_rsp.runs !== want_rsp.runs || seen_rsp.last !== want_rsp.last
                        || seen_rsp.run_slot !== want_rsp.run_slot
                        || seen_rsp.present !== want_rsp.present)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result %0d differs", checked);
                            $display("  expected %s", fmt_rsp(want_rsp));
                            $display("  actual   %s", fmt_rsp(seen_rsp));
                        end
                    end
                end
                ack_wait = (checked == 100 || checked == 900) ? LONG_HOLD : draw_wait();
            end
            out_ready <= (ack_wait == 0);
            if (ack_wait > 0)
            begin
                ack_wait--;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        logic [WORD_W-1:0] lo;
        int                ph;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        push_req('{rrts_pkg::ACT_TICK, rnd64(), rnd64(), 3'd0});
        push_req('{rrts_pkg::ACT_START, rnd64(), 64'd5, 3'd0});
        push_req('{rrts_pkg::ACT_STATS, rnd64(), 64'd0, 3'd7});
        settle();
        write_reg(rrts_pkg::CFG_STACK_BASE, 64'hFFFF_FFFF_FFFF_80B0);
        push_req('{rrts_pkg::ACT_ADD, rnd64(), 64'd0, 3'd0});
        settle();
        write_reg(rrts_pkg::CFG_STACK_BASE, 64'hFFFF_FFFF_FFFF_0000);
        write_reg(rrts_pkg::CFG_SLICE_TICKS, 64'hFFFF_FFFF_0000_0000);
        lo = stack_floor(0);
        push_req('{rrts_pkg::ACT_ADD, rnd64(), 64'd0, 3'd0});
        push_req('{rrts_pkg::ACT_START, rnd64(), 64'd100, 3'd0});
        push_req('{rrts_pkg::ACT_TICK, 64'd0, 64'd100, 3'd0});
        push_req('{rrts_pkg::ACT_TICK, lo + 64'd4, 64'd100, 3'd0});
        push_req('{rrts_pkg::ACT_TICK, lo - 64'd8, 64'd100, 3'd0});
        push_req('{rrts_pkg::ACT_TICK, lo + STACK_BYTES - FRAME_BYTES + 64'd8, 64'd100, 3'd0});
        push_req('{rrts_pkg::ACT_TICK, lo, 64'd100, 3'd0});
        push_req('{rrts_pkg::ACT_TICK, lo + STACK_BYTES - FRAME_BYTES, 64'd250, 3'd0});
        push_req('{rrts_pkg::ACT_ADD, rnd64(), 64'd0, 3'd0});
        push_req('{rrts_pkg::ACT_TICK, lo + 64'd8, 64'd251, 3'd0});
        push_req('{rrts_pkg::ACT_TICK, stack_floor(1) + 64'd8, 64'd252, 3'd0});
        push_req('{rrts_pkg::ACT_START, rnd64(), '1, 3'd0});
        settle();
        write_reg(rrts_pkg::CFG_STACK_BASE, 64'd0);
        repeat (7) push_req('{rrts_pkg::ACT_ADD, rnd64(), rnd64(),
                              SLOT_W'($urandom_range(0, 7))});
        push_req('{rrts_pkg::ACT_TICK, 64'd8, 64'd0, 3'd0});
        push_req('{rrts_pkg::ACT_TICK, STACK_BYTES + 64'd8, 64'd1, 3'd0});
        push_req('{rrts_pkg::ACT_STATS, rnd64(), rnd64(), 3'd1});
        push_req('{rrts_pkg::ACT_STATS, rnd64(), rnd64(), 3'd7});

        for (ph = 0; ph < SETTINGS_N; ph++)
        begin
            settle();
            write_reg(rrts_pkg::CFG_SLICE_TICKS, setting_slice[ph]);
            write_reg(rrts_pkg::CFG_STACK_BASE, setting_base[ph]);
            steady_pace = setting_steady[ph];
            repeat (setting_items[ph])
            begin
                wait_driver();
                push_req(random_req());
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d requests: %0d add, %0d start, %0d tick, %0d stats",
                 accepted, act_count[0], act_count[1], act_count[2], act_count[3]);
        $display("%0d task switches, %0d rejected, %0d register writes, %0d mismatches",
                 switches, rejects, cfg_writes, mismatches);
        if (mismatches == 0 && rsp_q.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("%0d results never arrived", rsp_q.size());
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rrts_pkg.sv
hdl/round_robin_task_switcher_unit.sv
hdl/rrts_checker.sv
tb/testbench.sv
